/* rtl/core/i2c_transaction_sequencer_defines.svh */
// Assertion macros for the transaction sequencer.
// Included by the front and back modules; no other dependencies.
`ifndef I2C_TRANSACTION_SEQUENCER_DEFINES_SVH
`define I2C_TRANSACTION_SEQUENCER_DEFINES_SVH
`ifndef SYNTHESIS
`define I2CTS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define I2CTS_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define I2CTS_ASSERT(lbl, clk, rst_n, prop, msg)
`define I2CTS_ASSERT_NR(lbl, clk, prop, msg)
`endif
`endif

/* rtl/core/i2cts_pkg.sv */
// Shared types and constants of the transaction sequencer.
// No dependencies; imported by the top, front and back modules.
`default_nettype none
package i2cts_pkg;

  localparam int BUF_DEPTH = 32;
  localparam int IDX_W     = $clog2(BUF_DEPTH);
  localparam int POS_W     = $clog2(BUF_DEPTH + 1);
  localparam logic [POS_W-1:0] DEPTH_POS = POS_W'(BUF_DEPTH);

  typedef enum logic [2:0] {
    KIND_MWRITE,
    KIND_MREAD,
    KIND_LOAD,
    KIND_SETLEN,
    KIND_EVENT,
    KIND_READ,
    KIND_NOP
  } kind_t;

  typedef enum logic [2:0] {
    ROLE_IDLE = 3'd0,
    ROLE_MT   = 3'd1,
    ROLE_MR   = 3'd2,
    ROLE_ST   = 3'd3,
    ROLE_SR   = 3'd4
  } role_t;

  typedef enum logic [2:0] {
    CMD_NONE    = 3'd0,
    CMD_START   = 3'd1,
    CMD_STOP    = 3'd2,
    CMD_SEND    = 3'd3,
    CMD_ACK     = 3'd4,
    CMD_NACK    = 3'd5,
    CMD_RELEASE = 3'd6,
    CMD_RSTOP   = 3'd7
  } cmd_t;

  typedef enum logic [2:0] {
    ERR_NONE   = 3'd0,
    ERR_BUS    = 3'd1,
    ERR_NODEV  = 3'd2,
    ERR_ARB    = 3'd3,
    ERR_INDET  = 3'd4
  } err_t;

  typedef struct packed {
    kind_t            kind;
    logic [6:0]       addr;
    logic [POS_W-1:0] len;
    logic             idx_ok;
    logic [IDX_W-1:0] idx;
    logic [7:0]       data;
    logic [4:0]       status;
    logic [7:0]       rxb;
  } item_t;

endpackage
`default_nettype wire

/* rtl/core/i2cts_if.sv */
// Request and result channel interfaces of the transaction sequencer.
// No dependencies.
`default_nettype none
interface i2cts_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] req_type;
  logic [6:0] target_addr;
  logic [5:0] xfer_length;
  logic [4:0] buf_index;
  logic [7:0] data_byte;
  logic [4:0] status_code;
  logic [7:0] rx_byte;

  modport source (output valid, req_type, target_addr, xfer_length, buf_index,
                  data_byte, status_code, rx_byte, input ready);
  modport sink   (input valid, req_type, target_addr, xfer_length, buf_index,
                  data_byte, status_code, rx_byte, output ready);
endinterface

interface i2cts_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] bus_cmd;
  logic [7:0] tx_byte;
  logic       accepted;
  logic [2:0] error_code;
  logic [2:0] role_state;
  logic [5:0] rx_count;
  logic [7:0] read_data;
  logic       master_done;
  logic       slave_rx_done;

  modport source (output valid, bus_cmd, tx_byte, accepted, error_code, role_state,
                  rx_count, read_data, master_done, slave_rx_done, input ready);
  modport sink   (input valid, bus_cmd, tx_byte, accepted, error_code, role_state,
                  rx_count, read_data, master_done, slave_rx_done, output ready);
endinterface
`default_nettype wire

/* rtl/core/i2c_transaction_sequencer.sv */
// Top level of the transaction sequencer: front end, queue and back end.
// Depends on i2cts_pkg, i2cts_if, i2cts_front and i2cts_back.
//
//   channel   dir   modport       carries
//   in_ch     in    sink          requests, bus events, buffer loads and reads
//   out_ch    out   source        bus command, byte, error, role, flags
//
// One item a cycle sustained while out_ch does not stall; an item passes through
// the two-entry front queue and then the back-end output register on its way out;
// buffer reads come from registered RAMs in step with the output register.
// rst_n is synchronous: role idle, address and positions zero, queue empty.
// Buffers are not cleared; out_ch stalls back up through the queue to in_ch.
`default_nettype none
module i2c_transaction_sequencer import i2cts_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  i2cts_in_if.sink    in_ch,
  i2cts_out_if.source out_ch
);

  logic  q_valid;
  logic  q_ready;
  item_t q_item;

  i2cts_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_item  (q_item)
  );

  i2cts_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_item  (q_item),
    .out_ch  (out_ch)
  );

endmodule
`default_nettype wire

/* rtl/core/i2cts_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module i2cts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

/* rtl/core/i2cts_front.sv */
// Front end: accepts request items, classifies them and queues them.
// Depends on i2cts_pkg, i2cts_if and the assertion macro header.
`default_nettype none
`include "i2c_transaction_sequencer_defines.svh"
module i2cts_front import i2cts_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  i2cts_in_if.sink   in_ch,
  output logic       q_valid,
  input  logic       q_ready,
  output item_t      q_item
);

  localparam logic [2:0] REQ_MASTER_WRITE = 3'd0;
  localparam logic [2:0] REQ_MASTER_READ  = 3'd1;
  localparam logic [2:0] REQ_LOAD_SEND    = 3'd2;
  localparam logic [2:0] REQ_SET_REPLY    = 3'd3;
  localparam logic [2:0] REQ_BUS_EVENT    = 3'd4;
  localparam logic [2:0] REQ_READ_RECV    = 3'd5;
  localparam logic [1:0] Q_FULL           = 2'd2;

  item_t      item_in;
  item_t      q_mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       push, pop;

  always_comb begin
    item_in.addr   = in_ch.target_addr;
    item_in.len    = (32'(in_ch.xfer_length) > BUF_DEPTH) ? DEPTH_POS
                                                         : POS_W'(in_ch.xfer_length);
    item_in.idx_ok = 32'(in_ch.buf_index) < BUF_DEPTH;
    item_in.idx    = IDX_W'(in_ch.buf_index);
    item_in.data   = in_ch.data_byte;
    item_in.status = in_ch.status_code;
    item_in.rxb    = in_ch.rx_byte;
    case (in_ch.req_type)
      REQ_MASTER_WRITE: item_in.kind = KIND_MWRITE;
      REQ_MASTER_READ:  item_in.kind = KIND_MREAD;
      REQ_LOAD_SEND:    item_in.kind = KIND_LOAD;
      REQ_SET_REPLY:    item_in.kind = KIND_SETLEN;
      REQ_BUS_EVENT:    item_in.kind = KIND_EVENT;
      REQ_READ_RECV:    item_in.kind = KIND_READ;
      default:          item_in.kind = KIND_NOP;
    endcase
  end

  assign in_ch.ready = (count_r != Q_FULL);
  assign q_valid     = (count_r != 2'd0);
  assign q_item      = q_mem_r[rd_ptr_r];
  assign push        = in_ch.valid && in_ch.ready;
  assign pop         = q_valid && q_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ pop;
    case ({push, pop})
      2'b10:   count_nxt = count_r + 2'd1;
      2'b01:   count_nxt = count_r - 2'd1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= item_in;
    end
  end

  `I2CTS_ASSERT(a_q_bound, clk, rst_n, count_r <= Q_FULL, "queue count beyond depth")
  `I2CTS_ASSERT(a_q_grow, clk, rst_n, push && !pop |=> count_r == $past(count_r) + 2'd1, "queue count did not grow on push")
  `I2CTS_ASSERT_NR(a_q_reset, clk, !rst_n |=> count_r == 2'd0, "queue not empty after reset")

endmodule
`default_nettype wire

/* rtl/core/i2cts_back.sv */
// Back end: executes queued items against the bus role and buffers.
// Depends on i2cts_pkg, i2cts_if, i2cts_ram and the assertion macro header.
`default_nettype none
`include "i2c_transaction_sequencer_defines.svh"
module i2cts_back import i2cts_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  output logic        q_ready,
  input  item_t       q_item,
  i2cts_out_if.source out_ch
);

  localparam logic [4:0] ST_BUS_ERROR     = 5'h00;
  localparam logic [4:0] ST_START         = 5'h01;
  localparam logic [4:0] ST_REP_START     = 5'h02;
  localparam logic [4:0] ST_MT_SLA_ACK    = 5'h03;
  localparam logic [4:0] ST_MT_SLA_NACK   = 5'h04;
  localparam logic [4:0] ST_MT_DATA_ACK   = 5'h05;
  localparam logic [4:0] ST_MT_DATA_NACK  = 5'h06;
  localparam logic [4:0] ST_ARB_LOST      = 5'h07;
  localparam logic [4:0] ST_MR_SLA_ACK    = 5'h08;
  localparam logic [4:0] ST_MR_SLA_NACK   = 5'h09;
  localparam logic [4:0] ST_MR_DATA_ACK   = 5'h0A;
  localparam logic [4:0] ST_MR_DATA_NACK  = 5'h0B;
  localparam logic [4:0] ST_SR_SLA_ACK    = 5'h0C;
  localparam logic [4:0] ST_SR_ARB_SLA    = 5'h0D;
  localparam logic [4:0] ST_SR_GCALL      = 5'h0E;
  localparam logic [4:0] ST_SR_ARB_GCALL  = 5'h0F;
  localparam logic [4:0] ST_SR_DATA_ACK   = 5'h10;
  localparam logic [4:0] ST_SR_DATA_NACK  = 5'h11;
  localparam logic [4:0] ST_SR_GDATA_ACK  = 5'h12;
  localparam logic [4:0] ST_SR_GDATA_NACK = 5'h13;
  localparam logic [4:0] ST_SR_STOP       = 5'h14;
  localparam logic [4:0] ST_ST_SLA_ACK    = 5'h15;
  localparam logic [4:0] ST_ST_ARB_SLA    = 5'h16;
  localparam logic [4:0] ST_ST_DATA_ACK   = 5'h17;
  localparam logic [4:0] ST_ST_DATA_NACK  = 5'h18;
  localparam logic [4:0] ST_ST_LAST_ACK   = 5'h19;
  localparam logic [4:0] ST_NO_INFO       = 5'h1F;

  role_t            role_r, role_nxt;
  logic [7:0]       addr_rw_r, addr_rw_nxt;
  logic [POS_W-1:0] send_pos_r, send_pos_nxt;
  logic [POS_W-1:0] send_count_r, send_count_nxt;
  logic [POS_W-1:0] recv_pos_r, recv_pos_nxt;
  logic [POS_W-1:0] recv_count_r, recv_count_nxt;

  logic             out_valid_r;
  cmd_t             cmd_r, cmd;
  logic [7:0]       tx_r, tx;
  logic             acc_r, acc;
  err_t             err_r, err;
  role_t            role_o_r;
  logic [5:0]       rxcnt_r;
  logic             mdone_r, mdone;
  logic             sdone_r, sdone;
  logic             tx_ram_r, tx_ram;
  logic             rd_ram_r, rd_ram;
  logic             do_store;

  logic             issue;
  logic             rp_ok;
  logic [POS_W-1:0] rp_st;
  logic             mr_ack_pre, mr_ack_post;
  logic [POS_W-1:0] sp_base, sp_inc;
  logic             sp_base_ok;
  cmd_t             st_cmd;

  logic             s_we, s_re, r_we, r_re;
  logic [7:0]       s_rdata, r_rdata;

  assign q_ready = !out_valid_r || out_ch.ready;
  assign issue   = q_valid && q_ready;

  always_comb begin
    rp_ok       = recv_pos_r < DEPTH_POS;
    rp_st       = rp_ok ? recv_pos_r + POS_W'(1) : recv_pos_r;
    mr_ack_pre  = ({1'b0, recv_pos_r} + (POS_W+1)'(1)) < {1'b0, recv_count_r};
    mr_ack_post = ({1'b0, rp_st} + (POS_W+1)'(1)) < {1'b0, recv_count_r};
    sp_base     = (q_item.status == ST_ST_SLA_ACK || q_item.status == ST_ST_ARB_SLA)
                  ? '0 : send_pos_r;
    sp_base_ok  = sp_base < DEPTH_POS;
    sp_inc      = sp_base_ok ? sp_base + POS_W'(1) : sp_base;
    st_cmd      = (sp_inc < send_count_r) ? CMD_ACK : CMD_NACK;
  end

  always_comb begin
    role_nxt       = role_r;
    addr_rw_nxt    = addr_rw_r;
    send_pos_nxt   = send_pos_r;
    send_count_nxt = send_count_r;
    recv_pos_nxt   = recv_pos_r;
    recv_count_nxt = recv_count_r;
    cmd            = CMD_NONE;
    tx             = 8'h00;
    acc            = 1'b0;
    err            = ERR_NONE;
    sdone          = 1'b0;
    tx_ram         = 1'b0;
    rd_ram         = 1'b0;
    do_store       = 1'b0;
    case (q_item.kind)
      KIND_MWRITE: begin
        if (role_r == ROLE_IDLE) begin
          acc            = 1'b1;
          cmd            = CMD_START;
          role_nxt       = ROLE_MT;
          addr_rw_nxt    = {q_item.addr, 1'b0};
          send_pos_nxt   = '0;
          send_count_nxt = q_item.len;
        end
      end
      KIND_MREAD: begin
        if (role_r == ROLE_IDLE) begin
          acc            = 1'b1;
          cmd            = CMD_START;
          role_nxt       = ROLE_MR;
          addr_rw_nxt    = {q_item.addr, 1'b1};
          recv_pos_nxt   = '0;
          recv_count_nxt = q_item.len;
        end
      end
      KIND_SETLEN: send_count_nxt = q_item.len;
      KIND_READ:   rd_ram = q_item.idx_ok;
      KIND_EVENT: begin
        case (q_item.status)
          ST_BUS_ERROR: begin
            cmd = CMD_RSTOP; err = ERR_BUS; role_nxt = ROLE_IDLE;
          end
          ST_START, ST_REP_START: begin
            cmd = CMD_SEND; tx = addr_rw_r;
          end
          ST_MT_SLA_ACK, ST_MT_DATA_ACK: begin
            if (send_pos_r < send_count_r && sp_base_ok) begin
              cmd          = CMD_SEND;
              tx_ram       = 1'b1;
              send_pos_nxt = sp_inc;
            end else begin
              cmd = CMD_STOP; role_nxt = ROLE_IDLE;
            end
          end
          ST_MT_SLA_NACK, ST_MT_DATA_NACK, ST_MR_SLA_NACK: begin
            cmd = CMD_STOP; err = ERR_NODEV; role_nxt = ROLE_IDLE;
          end
          ST_ARB_LOST: begin
            cmd = CMD_RELEASE; err = ERR_ARB; role_nxt = ROLE_IDLE;
          end
          ST_MR_SLA_ACK: cmd = mr_ack_pre ? CMD_ACK : CMD_NACK;
          ST_MR_DATA_ACK: begin
            do_store = 1'b1;
            cmd      = mr_ack_post ? CMD_ACK : CMD_NACK;
          end
          ST_MR_DATA_NACK: begin
            do_store = 1'b1; cmd = CMD_STOP; role_nxt = ROLE_IDLE;
          end
          ST_SR_SLA_ACK, ST_SR_ARB_SLA, ST_SR_GCALL, ST_SR_ARB_GCALL: begin
            role_nxt = ROLE_SR; recv_pos_nxt = '0; cmd = CMD_ACK;
          end
          ST_SR_DATA_ACK, ST_SR_GDATA_ACK: begin
            do_store = 1'b1;
            cmd      = (rp_st < DEPTH_POS) ? CMD_ACK : CMD_NACK;
          end
          ST_SR_DATA_NACK, ST_SR_GDATA_NACK: cmd = CMD_NACK;
          ST_SR_STOP: begin
            cmd = CMD_ACK; sdone = 1'b1; role_nxt = ROLE_IDLE;
          end
          ST_ST_SLA_ACK, ST_ST_ARB_SLA, ST_ST_DATA_ACK: begin
            if (q_item.status != ST_ST_DATA_ACK) begin
              role_nxt = ROLE_ST;
            end
            tx_ram       = sp_base_ok;
            send_pos_nxt = sp_inc;
            cmd          = st_cmd;
          end
          ST_ST_DATA_NACK, ST_ST_LAST_ACK: begin
            cmd = CMD_ACK; role_nxt = ROLE_IDLE;
          end
          ST_NO_INFO: err = ERR_INDET;
          default: ;
        endcase
        if (do_store) begin
          recv_pos_nxt = rp_st;
        end
      end
      default: ;
    endcase
    mdone = (q_item.kind == KIND_EVENT) && (role_r == ROLE_MT || role_r == ROLE_MR)
            && (role_nxt == ROLE_IDLE);
  end

  assign s_we = issue && (q_item.kind == KIND_LOAD) && q_item.idx_ok;
  assign s_re = issue && tx_ram;
  assign r_we = issue && do_store && rp_ok;
  assign r_re = issue && rd_ram;

  i2cts_ram #(.WIDTH(8), .DEPTH(BUF_DEPTH)) u_send_ram (
    .clk   (clk),
    .we    (s_we),
    .waddr (q_item.idx),
    .wdata (q_item.data),
    .re    (s_re),
    .raddr (sp_base[IDX_W-1:0]),
    .rdata (s_rdata)
  );

  i2cts_ram #(.WIDTH(8), .DEPTH(BUF_DEPTH)) u_recv_ram (
    .clk   (clk),
    .we    (r_we),
    .waddr (recv_pos_r[IDX_W-1:0]),
    .wdata (q_item.rxb),
    .re    (r_re),
    .raddr (q_item.idx),
    .rdata (r_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      role_r       <= ROLE_IDLE;
      addr_rw_r    <= 8'h00;
      send_pos_r   <= '0;
      send_count_r <= '0;
      recv_pos_r   <= '0;
      recv_count_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (issue) begin
        role_r       <= role_nxt;
        addr_rw_r    <= addr_rw_nxt;
        send_pos_r   <= send_pos_nxt;
        send_count_r <= send_count_nxt;
        recv_pos_r   <= recv_pos_nxt;
        recv_count_r <= recv_count_nxt;
      end
      if (q_ready) begin
        out_valid_r <= q_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      cmd_r    <= cmd;
      tx_r     <= tx;
      acc_r    <= acc;
      err_r    <= err;
      role_o_r <= role_nxt;
      rxcnt_r  <= 6'(recv_pos_nxt);
      mdone_r  <= mdone;
      sdone_r  <= sdone;
      tx_ram_r <= tx_ram;
      rd_ram_r <= rd_ram;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.bus_cmd       = cmd_r;
  assign out_ch.tx_byte       = tx_ram_r ? s_rdata : tx_r;
  assign out_ch.accepted      = acc_r;
  assign out_ch.error_code    = err_r;
  assign out_ch.role_state    = role_o_r;
  assign out_ch.rx_count      = rxcnt_r;
  assign out_ch.read_data     = rd_ram_r ? r_rdata : 8'h00;
  assign out_ch.master_done   = mdone_r;
  assign out_ch.slave_rx_done = sdone_r;

  `I2CTS_ASSERT(a_issue_fills, clk, rst_n, issue |=> out_valid_r, "issued item missing from output stage")
  `I2CTS_ASSERT(a_mdone_idle, clk, rst_n, out_valid_r && mdone_r |-> role_o_r == ROLE_IDLE, "master done without idle role")
  `I2CTS_ASSERT(a_txram_cmd, clk, rst_n, out_valid_r && tx_ram_r |-> (cmd_r == CMD_SEND || cmd_r == CMD_ACK || cmd_r == CMD_NACK), "buffer byte with wrong command")

endmodule
`default_nettype wire
